[sv/cls_pkg.sv]
// Shared types and codes for the compacting list store.
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

  typedef logic [2:0]  req_t;
  typedef logic [5:0]  pos_t;
  typedef logic [63:0] word_t;
  typedef logic [2:0]  status_t;
  typedef logic [6:0]  count_t;
  typedef logic [6:0]  limit_t;

  localparam req_t REQ_APPEND    = 3'd0;
  localparam req_t REQ_READ      = 3'd1;
  localparam req_t REQ_OVERWRITE = 3'd2;
  localparam req_t REQ_REMOVE    = 3'd3;
  localparam req_t REQ_SEARCH    = 3'd4;
  localparam req_t REQ_CLEAR     = 3'd5;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_INDEX     = 3'd1;
  localparam status_t ST_ZERO      = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_NOT_FOUND = 3'd4;

  localparam limit_t LIMIT_RESET = 7'd64;

  typedef struct packed {
    status_t status;
    word_t   word_out;
    pos_t    found_at;
    count_t  entry_count;
  } res_t;

endpackage

`default_nettype wire

[sv/cls_ifs.sv]
// Handshake channels of the compacting list store: request, response, config.
`timescale 1ns / 1ps
`default_nettype none

interface cls_req_if;
  logic            valid;
  logic            ready;
  cls_pkg::req_t   req_type;
  cls_pkg::pos_t   position;
  cls_pkg::word_t  word_in;

  modport source (output valid, output req_type, output position, output word_in,
                  input ready);
  modport sink   (input valid, input req_type, input position, input word_in,
                  output ready);
endinterface

interface cls_rsp_if;
  logic              valid;
  logic              ready;
  cls_pkg::status_t  status;
  cls_pkg::word_t    word_out;
  cls_pkg::pos_t     found_at;
  cls_pkg::count_t   entry_count;

  modport source (output valid, output status, output word_out, output found_at,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input word_out, input found_at,
                  input entry_count, output ready);
endinterface

interface cls_cfg_if;
  logic             valid;
  logic             ready;
  cls_pkg::limit_t  capacity_limit;

  modport source (output valid, output capacity_limit, input ready);
  modport sink   (input valid, input capacity_limit, output ready);
endinterface

`default_nettype wire

[sv/cls_ram.sv]
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cls_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic           clk_i,
  input  wire logic           we_i,
  input  wire logic [AW-1:0]  waddr_i,
  input  wire cls_pkg::word_t wdata_i,
  input  wire logic           re_i,
  input  wire logic [AW-1:0]  raddr_i,
  output cls_pkg::word_t      rdata_o
);

  cls_pkg::word_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[sv/cls_ctrl.sv]
// Request sequencer: checks, read-modify-write, remove shift and search walk.
`timescale 1ns / 1ps
`default_nettype none

module cls_ctrl #(
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  cls_req_if.sink              req_i,
  input  wire cls_pkg::limit_t cap_i,
  output logic                 res_valid_o,
  output cls_pkg::res_t        res_o,
  input  wire logic            res_free_i
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 7) ? CW : 7;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FIRST  = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  cls_pkg::req_t     op_q, op_d;
  cls_pkg::word_t    word_q, word_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  cls_pkg::status_t  status_q, status_d;
  cls_pkg::word_t    wout_q, wout_d;
  cls_pkg::pos_t     found_q, found_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  cls_pkg::word_t    mem_wdata, mem_rdata;

  logic [XW-1:0]     count_x;
  logic              list_full;
  logic              pos_bad;
  logic              pos_has_next;
  logic              ptr_has_next;

  cls_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign count_x     = XW'(count_q);
  // effective limit is capacity_limit saturated to DEPTH
  assign list_full   = (count_x >= XW'(cap_i)) || (count_x >= XW'(DEPTH));
  assign pos_bad     = XW'(req_i.position) >= count_x;
  assign pos_has_next = ((CW+1)'(pos_q) + (CW+1)'(1)) < (CW+1)'(count_q);
  assign ptr_has_next = ((CW+1)'(ptr_q) + (CW+1)'(1)) < (CW+1)'(count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    op_d      = op_q;
    word_d    = word_q;
    pos_d     = pos_q;
    ptr_d     = ptr_q;
    status_d  = status_q;
    wout_d    = wout_q;
    found_d   = found_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q - AW'(1);
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d     = req_i.req_type;
          word_d   = req_i.word_in;
          pos_d    = AW'(req_i.position);
          status_d = cls_pkg::ST_OK;
          wout_d   = '0;
          found_d  = '0;
          state_d  = S_DONE;
          case (req_i.req_type)
            cls_pkg::REQ_APPEND: begin
              if (req_i.word_in == '0) begin
                status_d = cls_pkg::ST_ZERO;
              end else if (list_full) begin
                status_d = cls_pkg::ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_q);
                mem_wdata = req_i.word_in;
                count_d   = count_q + CW'(1);
              end
            end
            cls_pkg::REQ_READ, cls_pkg::REQ_OVERWRITE, cls_pkg::REQ_REMOVE: begin
              if (pos_bad) begin
                status_d = cls_pkg::ST_INDEX;
              end else if (req_i.req_type == cls_pkg::REQ_OVERWRITE &&
                           req_i.word_in == '0) begin
                status_d = cls_pkg::ST_ZERO;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(req_i.position);
                state_d   = S_FIRST;
              end
            end
            cls_pkg::REQ_SEARCH: begin
              if (req_i.word_in == '0) begin
                status_d = cls_pkg::ST_ZERO;
              end else if (count_q == '0) begin
                status_d = cls_pkg::ST_NOT_FOUND;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                state_d   = S_SEARCH;
              end
            end
            cls_pkg::REQ_CLEAR: begin
              count_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_FIRST: begin
        wout_d  = mem_rdata;
        state_d = S_DONE;
        case (op_q)
          cls_pkg::REQ_OVERWRITE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_q;
            mem_wdata = word_q;
          end
          cls_pkg::REQ_REMOVE: begin
            if (pos_has_next) begin
              mem_re    = 1'b1;
              mem_raddr = pos_q + AW'(1);
              ptr_d     = pos_q + AW'(1);
              state_d   = S_SHIFT;
            end else begin
              count_d = count_q - CW'(1);
            end
          end
          default: begin
          end
        endcase
      end

      // read runs one entry ahead, the write lands one place below it
      S_SHIFT: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_q - AW'(1);
        mem_wdata = mem_rdata;
        if (ptr_has_next) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end else begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end
      end

      S_SEARCH: begin
        if (mem_rdata == word_q) begin
          found_d = cls_pkg::pos_t'(ptr_q);
          state_d = S_DONE;
        end else if (ptr_has_next) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + AW'(1);
          ptr_d     = ptr_q + AW'(1);
        end else begin
          status_d = cls_pkg::ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end

      S_DONE: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    word_q   <= word_d;
    pos_q    <= pos_d;
    ptr_q    <= ptr_d;
    status_q <= status_d;
    wout_q   <= wout_d;
    found_q  <= found_d;
  end

  assign res_valid_o       = (state_q == S_DONE);
  assign res_o.status      = status_q;
  assign res_o.word_out    = wout_q;
  assign res_o.found_at    = found_q;
  assign res_o.entry_count = cls_pkg::count_t'(count_q);

endmodule

`default_nettype wire

[sv/compacting_list_store.sv]
// Compacting list store top level: config register, sequencer, output register.
// A search walks the entries from index 0 until it hits; a remove moves every
// entry above the position down by one place. No new item is taken until the
// result of the last has left the sequencer; request ready returns in the cycle
// after that, since the sequencer handles one item at a time.
// Reset: count 0, capacity_limit 64; store contents undefined, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module compacting_list_store #(
  parameter int DEPTH = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cls_req_if.sink   req_i,
  cls_rsp_if.source rsp_o,
  cls_cfg_if.sink   cfg_i
);

  cls_pkg::limit_t cap_q;
  logic            res_valid;
  logic            res_free;
  cls_pkg::res_t   res;
  logic            out_valid_q;
  cls_pkg::res_t   out_res_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= cls_pkg::LIMIT_RESET;
    end else if (cfg_i.valid) begin
      cap_q <= cfg_i.capacity_limit;
    end
  end

  cls_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  assign res_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_free && res_valid) begin
      out_res_q <= res;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_res_q.status;
  assign rsp_o.word_out    = out_res_q.word_out;
  assign rsp_o.found_at    = out_res_q.found_at;
  assign rsp_o.entry_count = out_res_q.entry_count;

  // the sequencer always leaves idle after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request ready stayed high after an item was taken");

  // failed requests return no word and no index
  a_error_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.status != cls_pkg::ST_OK) |->
      (rsp_o.word_out == '0 && rsp_o.found_at == '0))
    else $error("error response carries a word or an index");

  // a finished result waits in the sequencer until the output register frees
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res_free) |=> res_valid)
    else $error("result dropped while output register was full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (int'(rsp_o.entry_count) <= DEPTH))
    else $error("entry count beyond store depth");

endmodule

`default_nettype wire
